// ===== sv/wsd_pkg.sv =====
// Shared types and codes for the WebSocket frame deframer.
// Used by wsd_parser, wsd_out_reg and websocket_frame_deframer; no dependencies.
`timescale 1ns / 1ps

package wsd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Reject reasons
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_INCOMPLETE = 2'd1;
    localparam logic [1:0] ERR_FIN        = 2'd2;
    localparam logic [1:0] ERR_LEN64      = 2'd3;

    // 7-bit length field markers
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] KEY_BYTES = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  opcode;
        logic        payload_last;
        logic [15:0] frame_length;
        logic [1:0]  error_code;
    } wsd_result_t;

endpackage

// ===== sv/wsd_parser.sv =====
// Header decoder and payload counter: frame state registers plus next-state logic.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          data_byte,
    input  logic                chunk_last,
    output logic                res_valid,
    output wsd_pkg::wsd_result_t res
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT_HI  = 3'd2;
    localparam logic [2:0] PH_EXT_LO  = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DISCARD = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_reg, mask_next;
    logic        fin_reg, fin_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] left_reg, left_next;
    logic [2:0]  key_reg, key_next;

    logic        emit;
    logic        do_len_done;
    logic        do_body;
    logic [2:0]  end_phase;

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        fin_next    = fin_reg;
        length_next = length_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        emit        = 1'b0;
        do_len_done = 1'b0;
        do_body     = 1'b0;
        end_phase   = chunk_last ? PH_HDR0 : PH_DISCARD;
        res.kind         = wsd_pkg::KIND_BYTE;
        res.payload_byte = 8'h00;
        res.payload_last = 1'b0;
        res.frame_length = 16'h0000;
        res.error_code   = wsd_pkg::ERR_NONE;

        unique case (phase_reg)
            PH_HDR1:
            begin
                mask_next = data_byte[7];
                if (!fin_reg)
                begin
                    emit           = 1'b1;
                    res.kind       = wsd_pkg::KIND_REJECT;
                    res.error_code = wsd_pkg::ERR_FIN;
                    phase_next     = end_phase;
                end
                else if (data_byte[6:0] == wsd_pkg::LEN7_EXT64)
                begin
                    emit           = 1'b1;
                    res.kind       = wsd_pkg::KIND_REJECT;
                    res.error_code = wsd_pkg::ERR_LEN64;
                    phase_next     = end_phase;
                end
                else if (data_byte[6:0] == wsd_pkg::LEN7_EXT16)
                begin
                    phase_next = PH_EXT_HI;
                    if (chunk_last)
                    begin
                        emit           = 1'b1;
                        res.kind       = wsd_pkg::KIND_REJECT;
                        res.error_code = wsd_pkg::ERR_INCOMPLETE;
                        phase_next     = PH_HDR0;
                    end
                end
                else
                begin
                    length_next = {9'd0, data_byte[6:0]};
                    do_len_done = 1'b1;
                end
            end
            PH_EXT_HI:
            begin
                left_next  = {data_byte, 8'h00};
                phase_next = PH_EXT_LO;
                if (chunk_last)
                begin
                    emit           = 1'b1;
                    res.kind       = wsd_pkg::KIND_REJECT;
                    res.error_code = wsd_pkg::ERR_INCOMPLETE;
                    phase_next     = PH_HDR0;
                end
            end
            PH_EXT_LO:
            begin
                length_next = left_reg | {8'h00, data_byte};
                do_len_done = 1'b1;
            end
            PH_KEY:
            begin
                if (key_reg <= 3'd1)
                begin
                    key_next = 3'd0;
                    do_body  = 1'b1;
                end
                else
                begin
                    key_next = key_reg - 3'd1;
                    if (chunk_last)
                    begin
                        emit             = 1'b1;
                        res.kind         = wsd_pkg::KIND_REJECT;
                        res.frame_length = length_reg;
                        res.error_code   = wsd_pkg::ERR_INCOMPLETE;
                        phase_next       = PH_HDR0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit             = 1'b1;
                res.frame_length = length_reg;
                if (left_reg <= 16'd1)
                begin
                    left_next        = 16'd0;
                    phase_next       = end_phase;
                    res.payload_byte = data_byte;
                    res.payload_last = 1'b1;
                end
                else
                begin
                    left_next = left_reg - 16'd1;
                    // a short chunk replaces the byte with a reject
                    if (chunk_last)
                    begin
                        res.kind       = wsd_pkg::KIND_REJECT;
                        res.error_code = wsd_pkg::ERR_INCOMPLETE;
                        phase_next     = PH_HDR0;
                    end
                    else
                    begin
                        res.payload_byte = data_byte;
                    end
                end
            end
            PH_DISCARD:
            begin
                if (chunk_last)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // first header byte; the unused code lands here as well
                fin_next    = data_byte[7];
                opcode_next = data_byte[3:0];
                mask_next   = 1'b0;
                length_next = 16'd0;
                left_next   = 16'd0;
                key_next    = 3'd0;
                phase_next  = PH_HDR1;
                if (chunk_last)
                begin
                    emit           = 1'b1;
                    res.kind       = wsd_pkg::KIND_REJECT;
                    res.error_code = wsd_pkg::ERR_INCOMPLETE;
                    phase_next     = PH_HDR0;
                end
            end
        endcase

        // length decoded: skip the key if present, else start the body
        if (do_len_done)
        begin
            if (mask_next)
            begin
                key_next   = wsd_pkg::KEY_BYTES;
                phase_next = PH_KEY;
                if (chunk_last)
                begin
                    emit             = 1'b1;
                    res.kind         = wsd_pkg::KIND_REJECT;
                    res.frame_length = length_next;
                    res.error_code   = wsd_pkg::ERR_INCOMPLETE;
                    phase_next       = PH_HDR0;
                end
            end
            else
            begin
                do_body = 1'b1;
            end
        end

        if (do_body)
        begin
            if (length_next == 16'd0)
            begin
                emit             = 1'b1;
                res.kind         = wsd_pkg::KIND_EMPTY;
                res.payload_last = 1'b1;
                phase_next       = end_phase;
            end
            else
            begin
                left_next  = length_next;
                phase_next = PH_PAYLOAD;
                if (chunk_last)
                begin
                    emit             = 1'b1;
                    res.kind         = wsd_pkg::KIND_REJECT;
                    res.frame_length = length_next;
                    res.error_code   = wsd_pkg::ERR_INCOMPLETE;
                    phase_next       = PH_HDR0;
                end
            end
        end

        res.opcode = opcode_next;
    end

    assign res_valid = in_fire & emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= 4'd0;
            mask_reg   <= 1'b0;
            fin_reg    <= 1'b0;
            length_reg <= 16'd0;
            left_reg   <= 16'd0;
            key_reg    <= 3'd0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            fin_reg    <= fin_next;
            length_reg <= length_next;
            left_reg   <= left_next;
            key_reg    <= key_next;
        end
    end

endmodule

// ===== sv/wsd_out_reg.sv =====
// Result register between the parser and the output stream.
// Depends on wsd_pkg.
`timescale 1ns / 1ps

module wsd_out_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    input  wsd_pkg::wsd_result_t load_data,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_ready,
    output wsd_pkg::wsd_result_t out_data
);

    logic                 valid_reg;
    wsd_pkg::wsd_result_t data_reg;

    // free when empty or being drained this cycle
    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && load_valid)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== sv/websocket_frame_deframer.sv =====
// WebSocket frame deframer, top level.
// Depends on wsd_pkg, wsd_parser and wsd_out_reg.
//
// Input stream: one received byte per request on s_tdata, s_tlast on the last
// byte of a chunk. Each chunk starts with a frame header (FIN, opcode, mask
// bit, 7-bit length, optional 16-bit extended length, optional 4-byte key).
// Output stream: at most one result per input byte; m_tuser gives the kind
// (payload byte, empty frame, reject), m_tlast the final payload byte or the
// empty frame. A reject may follow payload bytes already sent: drop that frame.
// Bytes after the frame up to the chunk end produce no output.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless m_tready stalls the output, set by the
// single output register; the header decode and payload counter update finish
// within the accepting cycle. s_tready is low only while a result is held and
// m_tready is low. Reset clears the frame state to awaiting the first header
// byte and empties the output register.
`timescale 1ns / 1ps

module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] payload_byte, [11:8] opcode,
                                   // [27:12] frame_length, [29:28] error_code
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    logic                 in_fire;
    logic                 res_valid;
    wsd_pkg::wsd_result_t res;
    wsd_pkg::wsd_result_t out_res;

    assign in_fire = s_tvalid && s_tready;

    wsd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (s_tdata),
        .chunk_last (s_tlast),
        .res_valid  (res_valid),
        .res        (res)
    );

    wsd_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (res_valid),
        .load_data  (res),
        .slot_free  (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {2'b00, out_res.error_code, out_res.frame_length,
                      out_res.opcode, out_res.payload_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.payload_last;

endmodule

// ===== tb/tb_websocket_frame_deframer.sv =====
// Self-checking testbench for websocket_frame_deframer: drives byte chunks and
// checks every result against a frame decoder kept in the bench.
// Depends on wsd_pkg and websocket_frame_deframer.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

    typedef logic [7:0] byte_q_t [$];

    typedef enum logic [2:0] {
        AWAIT_HDR0,
        AWAIT_HDR1,
        AWAIT_EXT_HI,
        AWAIT_EXT_LO,
        SKIP_KEY,
        IN_PAYLOAD,
        DISCARD_REST
    } frame_phase_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Decoder state
    frame_phase_e phase_now = AWAIT_HDR0;
    logic [3:0]   opcode_now = 4'd0;
    logic         masked_now = 1'b0;
    logic         fin_now = 1'b0;
    logic [15:0]  frame_len_now = 16'd0;
    logic [15:0]  remaining_now = 16'd0;
    logic [2:0]   key_left_now = 3'd0;

    wsd_pkg::wsd_result_t expected_q [$];
    int          fail_count = 0;
    int          bytes_sent = 0;
    bit          full_rate = 1'b0;

    websocket_frame_deframer dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic wsd_pkg::wsd_result_t pack_result(input logic [1:0] kind,
                                                         input logic [7:0] b,
                                                         input logic [15:0] len,
                                                         input logic last,
                                                         input logic [1:0] err);
        wsd_pkg::wsd_result_t r;
        r.kind         = kind;
        r.payload_byte = b;
        r.opcode       = opcode_now;
        r.payload_last = last;
        r.frame_length = len;
        r.error_code   = err;
        return r;
    endfunction

    function automatic bit reject_frame(input logic [15:0] len, input logic [1:0] err,
                                        input bit last, output wsd_pkg::wsd_result_t res);
        phase_now = last ? AWAIT_HDR0 : DISCARD_REST;
        res = pack_result(wsd_pkg::KIND_REJECT, 8'h00, len, 1'b0, err);
        return 1'b1;
    endfunction

    // Header and key complete: empty frame, or arm the payload counter.
    function automatic bit open_body(input bit last, output wsd_pkg::wsd_result_t res);
        if (frame_len_now == 16'd0)
        begin
            phase_now = last ? AWAIT_HDR0 : DISCARD_REST;
            res = pack_result(wsd_pkg::KIND_EMPTY, 8'h00, 16'd0, 1'b1, wsd_pkg::ERR_NONE);
            return 1'b1;
        end
        remaining_now = frame_len_now;
        phase_now = IN_PAYLOAD;
        if (last)
            return reject_frame(frame_len_now, wsd_pkg::ERR_INCOMPLETE, 1'b1, res);
        return 1'b0;
    endfunction

    function automatic bit length_known(input bit last, output wsd_pkg::wsd_result_t res);
        if (masked_now)
        begin
            key_left_now = wsd_pkg::KEY_BYTES;
            phase_now = SKIP_KEY;
            if (last)
                return reject_frame(frame_len_now, wsd_pkg::ERR_INCOMPLETE, 1'b1, res);
            return 1'b0;
        end
        return open_body(last, res);
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input bit last,
                                       output wsd_pkg::wsd_result_t res);
        logic [6:0] len7;
        len7 = b[6:0];
        case (phase_now)
            AWAIT_HDR1:
            begin
                masked_now = b[7];
                if (!fin_now)
                    return reject_frame(16'd0, wsd_pkg::ERR_FIN, last, res);
                if (len7 == wsd_pkg::LEN7_EXT64)
                    return reject_frame(16'd0, wsd_pkg::ERR_LEN64, last, res);
                if (len7 == wsd_pkg::LEN7_EXT16)
                begin
                    phase_now = AWAIT_EXT_HI;
                    if (last)
                        return reject_frame(16'd0, wsd_pkg::ERR_INCOMPLETE, 1'b1, res);
                    return 1'b0;
                end
                frame_len_now = {9'd0, len7};
                return length_known(last, res);
            end
            AWAIT_EXT_HI:
            begin
                remaining_now = {b, 8'h00};
                phase_now = AWAIT_EXT_LO;
                if (last)
                    return reject_frame(16'd0, wsd_pkg::ERR_INCOMPLETE, 1'b1, res);
                return 1'b0;
            end
            AWAIT_EXT_LO:
            begin
                frame_len_now = remaining_now | {8'h00, b};
                return length_known(last, res);
            end
            SKIP_KEY:
            begin
                if (key_left_now <= 3'd1)
                begin
                    key_left_now = 3'd0;
                    return open_body(last, res);
                end
                key_left_now = key_left_now - 3'd1;
                if (last)
                    return reject_frame(frame_len_now, wsd_pkg::ERR_INCOMPLETE, 1'b1, res);
                return 1'b0;
            end
            IN_PAYLOAD:
            begin
                if (remaining_now <= 16'd1)
                begin
                    remaining_now = 16'd0;
                    phase_now = last ? AWAIT_HDR0 : DISCARD_REST;
                    res = pack_result(wsd_pkg::KIND_BYTE, b, frame_len_now, 1'b1,
                                      wsd_pkg::ERR_NONE);
                    return 1'b1;
                end
                remaining_now = remaining_now - 16'd1;
                // the reject takes the place of the cut-off payload byte
                if (last)
                    return reject_frame(frame_len_now, wsd_pkg::ERR_INCOMPLETE, 1'b1, res);
                res = pack_result(wsd_pkg::KIND_BYTE, b, frame_len_now, 1'b0,
                                  wsd_pkg::ERR_NONE);
                return 1'b1;
            end
            DISCARD_REST:
            begin
                if (last)
                    phase_now = AWAIT_HDR0;
                return 1'b0;
            end
            default:
            begin
                fin_now       = b[7];
                opcode_now    = b[3:0];
                masked_now    = 1'b0;
                frame_len_now = 16'd0;
                remaining_now = 16'd0;
                key_left_now  = 3'd0;
                phase_now     = AWAIT_HDR1;
                if (last)
                    return reject_frame(16'd0, wsd_pkg::ERR_INCOMPLETE, 1'b1, res);
                return 1'b0;
            end
        endcase
    endfunction

    // Send one byte; keep s_tvalid high across back-to-back requests.
    task automatic send_byte(input logic [7:0] b, input bit last);
        wsd_pkg::wsd_result_t res;
        @(negedge clk);
        while (!full_rate && $urandom_range(0, 99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        if (decode_byte(b, last, res))
            expected_q.push_back(res);
        bytes_sent++;
    endtask

    task automatic send_chunk(input byte_q_t chunk);
        for (int i = 0; i < chunk.size(); i++)
            send_byte(chunk[i], i == chunk.size() - 1);
    endtask

    // Mostly well-formed frames with random content; some noise, cuts and trailers.
    function automatic byte_q_t make_random_chunk();
        byte_q_t     c;
        int          pick;
        logic [15:0] plen;
        bit          masked;
        bit          must_cut;
        int          cut;
        must_cut = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 8)) c.push_back(8'($urandom));
            return c;
        end
        c.push_back({($urandom_range(0, 99) < 90) ? 1'b1 : 1'b0, 3'($urandom), 4'($urandom)});
        masked = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            c.push_back({masked, wsd_pkg::LEN7_EXT64});
            plen = 16'($urandom_range(0, 6));
        end
        else if (pick < 30)
        begin
            c.push_back({masked, wsd_pkg::LEN7_EXT16});
            if ($urandom_range(0, 1) == 0)
                plen = 16'($urandom_range(0, 40));
            else
            begin
                plen = 16'($urandom);
                must_cut = (plen > 16'd40);
            end
            c.push_back(plen[15:8]);
            c.push_back(plen[7:0]);
        end
        else
        begin
            plen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 125))
                                               : 16'($urandom_range(0, 12));
            c.push_back({masked, plen[6:0]});
        end
        if (masked)
            repeat (4) c.push_back(8'($urandom));
        for (int i = 0; i < plen && i < 130; i++)
            c.push_back(8'($urandom));
        if (must_cut || $urandom_range(0, 99) < 15)
        begin
            cut = $urandom_range(1, c.size());
            while (c.size() > cut)
                void'(c.pop_back());
        end
        else if ($urandom_range(0, 99) < 25)
            repeat ($urandom_range(1, 4)) c.push_back(8'($urandom));
        return c;
    endfunction

    task automatic test_directed_frames();
        byte_q_t chunk;
        chunk = '{8'h81};                                   // chunk ends on first byte
        send_chunk(chunk);
        chunk = '{8'h01, 8'h05, 8'hAA};                     // FIN clear, rest dropped
        send_chunk(chunk);
        chunk = '{8'h82, 8'hFF};                            // 64-bit length
        send_chunk(chunk);
        chunk = '{8'h89, 8'h00};                            // empty frame
        send_chunk(chunk);
        chunk = '{8'h8F, 8'h82, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFF, 8'h00};
        send_chunk(chunk);
        chunk = '{8'h80, 8'h7E, 8'h00, 8'h03, 8'h00, 8'h5A, 8'hA5};
        send_chunk(chunk);
        chunk = '{8'h82, 8'h7E, 8'hFF, 8'hFF};              // cut after extended length
        send_chunk(chunk);
    endtask

    task automatic test_random_chunks(input int n_bytes);
        byte_q_t chunk;
        int      target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target)
        begin
            chunk = make_random_chunk();
            send_chunk(chunk);
        end
    endtask

    // Withdraw the last request before waiting so it is not taken again.
    task automatic test_pause_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        test_random_chunks(40);
    endtask

    task automatic test_back_to_back();
        full_rate = 1'b1;
        test_random_chunks(400);
        full_rate = 1'b0;
    endtask

    always @(negedge clk)
        m_tready <= full_rate ? 1'b1 : ($urandom_range(0, 99) >= 26);

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        wsd_pkg::wsd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending: tuser %0h tdata %0h",
                       m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
                check_field("opcode", 32'(want.opcode), 32'(m_tdata[11:8]));
                check_field("payload_last", 32'(want.payload_last), 32'(m_tlast));
                check_field("frame_length", 32'(want.frame_length), 32'(m_tdata[27:12]));
                check_field("error_code", 32'(want.error_code), 32'(m_tdata[29:28]));
            end
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_directed_frames();
        test_random_chunks(800);
        test_pause_until_drained();
        test_back_to_back();
        test_random_chunks(650);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (5) @(posedge clk);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
sv/wsd_pkg.sv
sv/wsd_parser.sv
sv/wsd_out_reg.sv
sv/websocket_frame_deframer.sv
tb/tb_websocket_frame_deframer.sv
